// ----- rtl/eds_pkg.sv -----
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and constants of the encoder detent stepper.
// ----------------------------------------------------------------------------
package eds_pkg;

   localparam int MAX_LANES = 2;

   localparam int COUNT_W   = 32;
   localparam int TIME_W    = 16;
   localparam int PEND_W    = 7;
   localparam int TPS_W     = 4;
   localparam int LIMIT_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [TPS_W-1:0]   TPS_RESET      = 4'd4;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 6'd12;
   localparam logic [TIME_W-1:0]  DEBOUNCE_RESET = 16'd2000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TPS      = 2'd0,
      CSR_LIMIT    = 2'd1,
      CSR_DEBOUNCE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TPS_W-1:0]   tps;
      logic [LIMIT_W-1:0] limit;
      logic [TIME_W-1:0]  debounce;
   } cfg_type;

   typedef struct packed {
      logic update;
      logic prime;
      logic up_take;
      logic down_take;
   } lane_ctl_type;

   typedef struct packed {
      logic              up_ok;
      logic              down_ok;
      logic [PEND_W-1:0] pend_out;
   } lane_sts_type;

endpackage

// ----- rtl/eds_if.sv -----
// ----------------------------------------------------------------------------
// eds_if
// Request, response and register write channels of the encoder detent stepper.
// ----------------------------------------------------------------------------
interface eds_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] count_a;
   logic signed [31:0] count_b;
   logic [15:0]        elapsed_us;
   logic               ask_up;
   logic               ask_down;

   modport source (output valid, count_a, count_b, elapsed_us, ask_up, ask_down,
                   input ready);
   modport sink   (input valid, count_a, count_b, elapsed_us, ask_up, ask_down,
                   output ready);
endinterface

interface eds_rsp_if;
   logic              valid;
   logic              ready;
   logic              step_up;
   logic              step_down;
   logic signed [6:0] pending_a_out;
   logic signed [6:0] pending_b_out;

   modport source (output valid, step_up, step_down, pending_a_out, pending_b_out,
                   input ready);
   modport sink   (input valid, step_up, step_down, pending_a_out, pending_b_out,
                   output ready);
endinterface

interface eds_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/eds_lane.sv -----
// ----------------------------------------------------------------------------
// eds_lane
// One encoder: count delta, clamped pending sum, debounce timer, step checks.
// ----------------------------------------------------------------------------
module eds_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  eds_pkg::lane_ctl_type ctl,
   input  eds_pkg::cfg_type     cfg,
   input  logic [31:0]          count,
   input  logic [15:0]          elapsed_us,
   output eds_pkg::lane_sts_type sts
);
   import eds_pkg::*;

   logic [COUNT_W-1:0]       last_count_ff;
   logic [PEND_W-1:0]        pending_ff, pending_in;
   logic [TIME_W-1:0]        since_ff, since_in;

   logic [TIME_W:0]          time_sum;
   logic [TIME_W-1:0]        time_add, time_up;
   logic [COUNT_W-1:0]       delta;
   logic signed [COUNT_W:0]  sum, lim, lim_neg;
   logic [PEND_W-1:0]        pend_clamp, pend_up, pend_down, tps7;
   logic signed [PEND_W:0]   tps8, pend_clamp8, pend_up8;

   always_comb begin
      time_sum = {1'b0, since_ff} + {1'b0, elapsed_us};
      time_add = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

      delta   = last_count_ff - count;
      sum     = $signed({{(COUNT_W + 1 - PEND_W){pending_ff[PEND_W-1]}}, pending_ff})
              + $signed({delta[COUNT_W-1], delta});
      lim     = $signed({{(COUNT_W + 1 - LIMIT_W){1'b0}}, cfg.limit});
      lim_neg = -lim;
      if (sum > lim) begin
         pend_clamp = lim[PEND_W-1:0];
      end else if (sum < lim_neg) begin
         pend_clamp = lim_neg[PEND_W-1:0];
      end else begin
         pend_clamp = sum[PEND_W-1:0];
      end

      tps7        = {{(PEND_W - TPS_W){1'b0}}, cfg.tps};
      tps8        = $signed({1'b0, tps7});
      pend_clamp8 = $signed({pend_clamp[PEND_W-1], pend_clamp});

      sts.up_ok = (time_add >= cfg.debounce) && (pend_clamp8 >= tps8);

      pend_up  = ctl.up_take ? pend_clamp - tps7 : pend_clamp;
      time_up  = ctl.up_take ? '0 : time_add;
      pend_up8 = $signed({pend_up[PEND_W-1], pend_up});

      sts.down_ok = (time_up >= cfg.debounce) && (pend_up8 <= -tps8);

      pend_down = ctl.down_take ? pend_up + tps7 : pend_up;

      if (ctl.prime) begin
         pending_in = pending_ff;
         since_in   = since_ff;
      end else begin
         pending_in = pend_down;
         since_in   = ctl.down_take ? '0 : time_up;
      end
      sts.pend_out = pending_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         last_count_ff <= count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         since_ff   <= '0;
      end else if (ctl.update) begin
         pending_ff <= pending_in;
         since_ff   <= since_in;
      end
   end

endmodule

// ----- rtl/encoder_detent_stepper_top.sv -----
// ----------------------------------------------------------------------------
// encoder_detent_stepper_top
// Turns raw quadrature counts into debounced up and down menu steps.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one frame: counts of encoders A and B, microseconds since the
//   previous frame, and up and down step asks. rsp returns one result per
//   frame: step_up, step_down and both pending sums after the frame.
//   csr writes transitions_per_step (index 0), pending_limit (index 1) and
//   step_debounce_us (index 2); other indexes are ignored. csr is always
//   ready; write it only while no frame is in flight.
// Timing:
//   A request is taken into an input register, processed in one pass of
//   short logic and lands in the response register, which raises rsp valid.
//   One request per cycle is sustained while rsp is taken; the input
//   register and the response register are the only pipeline stages.
// Reset:
//   Clears both stages, the sums, the timers and the registers to their
//   defaults. The first frame after reset only loads the counts.
// Stall:
//   While rsp is held, one more request is taken into the input register,
//   then req.ready drops until the response is taken.
// ----------------------------------------------------------------------------
module encoder_detent_stepper_top #(
   parameter int NUM_ENCODERS = 2
) (
   input  logic clock,
   input  logic reset,
   eds_req_if.sink   req,
   eds_rsp_if.source rsp,
   eds_csr_if.sink   csr
);
   import eds_pkg::*;

   cfg_type            cfg_ff;

   logic               req_valid_ff;
   logic [COUNT_W-1:0] count_a_ff, count_b_ff;
   logic [TIME_W-1:0]  elapsed_ff;
   logic               ask_up_ff, ask_down_ff;

   logic               primed_ff;

   logic               rsp_valid_ff;
   logic               step_up_ff, step_down_ff;
   logic [PEND_W-1:0]  pend_a_ff, pend_b_ff;

   logic               advance;
   logic               up_found, down_found;
   logic [COUNT_W-1:0] lane_count [MAX_LANES];
   lane_ctl_type       lane_ctl   [MAX_LANES];
   lane_sts_type       lane_sts   [MAX_LANES];
   logic [MAX_LANES-1:0] up_take, down_take;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign lane_count[0] = count_a_ff;
   assign lane_count[1] = count_b_ff;

   always_comb begin
      up_take    = '0;
      down_take  = '0;
      up_found   = 1'b0;
      down_found = 1'b0;
      for (int i = 0; i < MAX_LANES; i++) begin
         if (!up_found && primed_ff && ask_up_ff && lane_sts[i].up_ok) begin
            up_take[i] = 1'b1;
            up_found   = 1'b1;
         end
      end
      for (int i = 0; i < MAX_LANES; i++) begin
         if (!down_found && primed_ff && ask_down_ff && lane_sts[i].down_ok) begin
            down_take[i] = 1'b1;
            down_found   = 1'b1;
         end
      end
   end

   for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
      if (g < NUM_ENCODERS) begin : g_on
         always_comb begin
            lane_ctl[g].update    = advance;
            lane_ctl[g].prime     = !primed_ff;
            lane_ctl[g].up_take   = up_take[g];
            lane_ctl[g].down_take = down_take[g];
         end

         eds_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctl        (lane_ctl[g]),
            .cfg        (cfg_ff),
            .count      (lane_count[g]),
            .elapsed_us (elapsed_ff),
            .sts        (lane_sts[g])
         );
      end else begin : g_off
         assign lane_ctl[g] = '0;
         assign lane_sts[g] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tps      <= TPS_RESET;
         cfg_ff.limit    <= LIMIT_RESET;
         cfg_ff.debounce <= DEBOUNCE_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_TPS:      cfg_ff.tps      <= csr.data[TPS_W-1:0];
            CSR_LIMIT:    cfg_ff.limit    <= csr.data[LIMIT_W-1:0];
            CSR_DEBOUNCE: cfg_ff.debounce <= csr.data[TIME_W-1:0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
      end else begin
         if (req.ready) begin
            req_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            primed_ff    <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         count_a_ff  <= req.count_a;
         count_b_ff  <= req.count_b;
         elapsed_ff  <= req.elapsed_us;
         ask_up_ff   <= req.ask_up;
         ask_down_ff <= req.ask_down;
      end
      if (advance) begin
         step_up_ff   <= |up_take;
         step_down_ff <= |down_take;
         pend_a_ff    <= lane_sts[0].pend_out;
         pend_b_ff    <= lane_sts[1].pend_out;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.step_up       = step_up_ff;
   assign rsp.step_down     = step_down_ff;
   assign rsp.pending_a_out = pend_a_ff;
   assign rsp.pending_b_out = pend_b_ff;

endmodule
